@@ hw/rtl/stlp_pkg.sv @@
// Shared types and constants for the binary mesh triangle parser.
`default_nettype none
package stlp_pkg;

  localparam int unsigned HEADER_BYTES   = 80;
  localparam int unsigned PREAMBLE_BYTES = 84;
  localparam int unsigned RECORD_BYTES   = 50;
  localparam int unsigned NORMAL_BYTES   = 12;
  localparam int unsigned VERTEX_WORDS   = 9;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] KIND_TRIANGLE   = 3'd0;
  localparam logic [2:0] KIND_FILE_OK    = 3'd1;
  localparam logic [2:0] KIND_TOO_SHORT  = 3'd2;
  localparam logic [2:0] KIND_ZERO_COUNT = 3'd3;
  localparam logic [2:0] KIND_SIZE_ERR   = 3'd4;
  localparam logic [2:0] KIND_NON_FINITE = 3'd5;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] vertex0_x;
    logic [31:0] vertex0_y;
    logic [31:0] vertex0_z;
    logic [31:0] vertex1_x;
    logic [31:0] vertex1_y;
    logic [31:0] vertex1_z;
    logic [31:0] vertex2_x;
    logic [31:0] vertex2_y;
    logic [31:0] vertex2_z;
    logic        last_of_run;
  } result_item_t;

  // One byte's worth of results: a first kind and an optional second one.
  typedef struct packed {
    logic [2:0]                     kind_first;
    logic                           has_second;
    logic [2:0]                     kind_second;
    logic [VERTEX_WORDS-1:0][31:0]  words;
  } event_t;

endpackage
`default_nettype wire

@@ hw/rtl/stlp_front.sv @@
// Byte parser: tracks header, count and record position, assembles vertex words.
`default_nettype none
module stlp_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  accept,
  input  stlp_pkg::byte_item_t byte_item,
  output logic                 ev_valid,
  output stlp_pkg::event_t     ev
);
  import stlp_pkg::*;

  logic [6:0]  header_position, header_position_next;
  logic [31:0] triangle_count, triangle_count_next;
  logic [31:0] triangles_left, triangles_left_next;
  logic [5:0]  record_offset, record_offset_next;
  logic [31:0] vertex_words [VERTEX_WORDS];
  logic [31:0] vertex_words_next [VERTEX_WORDS];
  logic        non_finite_seen, non_finite_seen_next;
  logic        stream_finished, stream_finished_next;

  logic [6:0]  pos_inc;
  logic [5:0]  rel;
  logic [3:0]  word_sel;
  logic [1:0]  lane;
  logic        in_vertex;
  logic [7:0]  exponent;
  logic [31:0] left_dec;
  logic        nf_new;
  logic        clear_all;
  logic [7:0]  b;
  logic        eof;

  assign b        = byte_item.byte_value;
  assign eof      = byte_item.end_of_file;
  assign pos_inc  = header_position + 7'd1;
  assign rel      = record_offset - 6'(NORMAL_BYTES);
  assign word_sel = rel[5:2];
  assign lane     = rel[1:0];
  assign in_vertex = (record_offset >= 6'(NORMAL_BYTES)) &&
                     (record_offset < 6'(NORMAL_BYTES + 4 * VERTEX_WORDS));
  assign left_dec = triangles_left - 32'd1;

  always_comb begin
    header_position_next = header_position;
    triangle_count_next  = triangle_count;
    triangles_left_next  = triangles_left;
    record_offset_next   = record_offset;
    non_finite_seen_next = non_finite_seen;
    stream_finished_next = stream_finished;
    for (int i = 0; i < VERTEX_WORDS; i++) vertex_words_next[i] = vertex_words[i];
    ev_valid  = 1'b0;
    ev        = '0;
    clear_all = 1'b0;
    exponent  = '0;
    nf_new    = non_finite_seen;
    for (int i = 0; i < VERTEX_WORDS; i++) ev.words[i] = vertex_words[i];

    if (stream_finished) begin
      clear_all = eof;
    end else if (header_position < 7'(PREAMBLE_BYTES)) begin
      if (header_position >= 7'(HEADER_BYTES)) begin
        if (header_position == 7'(HEADER_BYTES)) triangle_count_next = '0;
        triangle_count_next[{header_position[1:0], 3'b000} +: 8] = b;
      end
      header_position_next = pos_inc;
      if (pos_inc == 7'(PREAMBLE_BYTES)) begin
        triangles_left_next = triangle_count_next;
        record_offset_next  = '0;
      end
      if (eof) begin
        ev_valid  = 1'b1;
        clear_all = 1'b1;
        if (pos_inc < 7'(PREAMBLE_BYTES)) ev.kind_first = KIND_TOO_SHORT;
        else if (triangle_count_next == '0) ev.kind_first = KIND_ZERO_COUNT;
        else ev.kind_first = KIND_SIZE_ERR;
      end else if (pos_inc == 7'(PREAMBLE_BYTES) && triangle_count_next == '0) begin
        ev_valid             = 1'b1;
        ev.kind_first        = KIND_ZERO_COUNT;
        stream_finished_next = 1'b1;
      end
    end else if (triangles_left == '0) begin
      ev_valid      = 1'b1;
      ev.kind_first = KIND_SIZE_ERR;
      if (eof) clear_all = 1'b1;
      else stream_finished_next = 1'b1;
    end else begin
      if (record_offset == '0) nf_new = 1'b0;
      if (in_vertex) begin
        for (int i = 0; i < VERTEX_WORDS; i++) begin
          if (word_sel == 4'(i)) vertex_words_next[i][{lane, 3'b000} +: 8] = b;
        end
        exponent = {b[6:0], vertex_words[word_sel][23]};
        if (lane == 2'd3 && exponent == 8'hFF) nf_new = 1'b1;
      end
      non_finite_seen_next = nf_new;
      if (record_offset >= 6'(RECORD_BYTES - 1)) begin
        record_offset_next  = '0;
        triangles_left_next = left_dec;
        ev_valid            = 1'b1;
        if (nf_new) begin
          ev.kind_first = KIND_NON_FINITE;
          if (eof) clear_all = 1'b1;
          else stream_finished_next = 1'b1;
        end else begin
          ev.kind_first = KIND_TRIANGLE;
          if (eof) begin
            ev.has_second  = 1'b1;
            ev.kind_second = (left_dec == '0) ? KIND_FILE_OK : KIND_SIZE_ERR;
            clear_all      = 1'b1;
          end
        end
      end else begin
        record_offset_next = record_offset + 6'd1;
        if (eof) begin
          ev_valid      = 1'b1;
          ev.kind_first = KIND_SIZE_ERR;
          clear_all     = 1'b1;
        end
      end
    end

    // End of file: drop back to the start of a new file.
    if (clear_all) begin
      header_position_next = '0;
      triangle_count_next  = '0;
      triangles_left_next  = '0;
      record_offset_next   = '0;
      non_finite_seen_next = 1'b0;
      stream_finished_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
      triangle_count  <= '0;
      triangles_left  <= '0;
      record_offset   <= '0;
      non_finite_seen <= 1'b0;
      stream_finished <= 1'b0;
    end else if (accept) begin
      header_position <= header_position_next;
      triangle_count  <= triangle_count_next;
      triangles_left  <= triangles_left_next;
      record_offset   <= record_offset_next;
      non_finite_seen <= non_finite_seen_next;
      stream_finished <= stream_finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < VERTEX_WORDS; i++) vertex_words[i] <= vertex_words_next[i];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/stlp_queue.sv @@
// Short event queue between the byte parser and the result stage.
`default_nettype none
module stlp_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    wr_en,
  input  stlp_pkg::event_t       wr_data,
  output logic                   full,
  input  wire                    rd_en,
  output stlp_pkg::event_t       rd_data,
  output logic                   empty
);
  import stlp_pkg::*;

  event_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign full    = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      if (do_wr && !do_rd) count <= count + QUEUE_CNT_W'(1);
      else if (do_rd && !do_wr) count <= count - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule
`default_nettype wire

@@ hw/rtl/stlp_back.sv @@
// Result stage: expands queued events into single results in an output register.
`default_nettype none
module stlp_back (
  input  wire                      clk,
  input  wire                      rst,
  input  stlp_pkg::event_t         head,
  input  wire                      head_empty,
  output logic                     head_pop,
  input  wire                      pop,
  output logic                     empty,
  output stlp_pkg::result_item_t   result
);
  import stlp_pkg::*;

  logic         out_valid;
  logic         second_phase;
  logic         load;
  logic         take_second;
  logic         split;
  logic [2:0]   kind_sel;
  result_item_t staged;

  assign load        = !out_valid || pop;
  assign split       = head.has_second && !second_phase;
  assign take_second = head.has_second && second_phase;
  assign head_pop    = load && !head_empty && !split;
  assign empty       = !out_valid;
  assign kind_sel    = take_second ? head.kind_second : head.kind_first;

  always_comb begin
    staged             = '0;
    staged.kind        = kind_sel;
    staged.last_of_run = !split;
    // Zero the vertices on anything but a triangle.
    if (kind_sel == KIND_TRIANGLE) begin
      staged.vertex0_x = head.words[0];
      staged.vertex0_y = head.words[1];
      staged.vertex0_z = head.words[2];
      staged.vertex1_x = head.words[3];
      staged.vertex1_y = head.words[4];
      staged.vertex1_z = head.words[5];
      staged.vertex2_x = head.words[6];
      staged.vertex2_y = head.words[7];
      staged.vertex2_z = head.words[8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      second_phase <= 1'b0;
    end else if (load) begin
      out_valid <= !head_empty;
      if (!head_empty) second_phase <= split;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !head_empty) result <= staged;
  end

endmodule
`default_nettype wire

@@ hw/rtl/binary_stl_triangle_parser.sv @@
// Top level of the streaming binary mesh triangle parser.
// Throughput: one byte per cycle; input stalls only while the event queue holds four events.
// An end-of-file byte with two results gives them on the output one after the other.
// A byte's first result is written into the event queue at its byte's transfer, then into the output register.
// A four-entry event queue decouples the byte parser from the output register.
// Reset (rst, synchronous) clears parser position, counts and flags, and empties queue and output register.
`default_nettype none
module binary_stl_triangle_parser (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push,
  output logic                     full,
  input  stlp_pkg::byte_item_t     byte_item,
  input  wire                      pop,
  output logic                     empty,
  output stlp_pkg::result_item_t   result
);
  import stlp_pkg::*;

  logic   accept;
  logic   ev_valid;
  event_t ev;
  event_t head;
  logic   head_empty;
  logic   head_pop;

  assign accept = push && !full;

  stlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .byte_item (byte_item),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  stlp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && ev_valid),
    .wr_data (ev),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head),
    .empty   (head_empty)
  );

  stlp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule
`default_nettype wire
